/* rtl/fdat_pkg.sv */
// Shared types and constants for the flow duration alarm timer.
// Holds the register index codes, alert and request codes, and the bundles between modules.
// No dependencies.
`default_nettype none

package fdat_pkg;

  // Millisecond thresholds fit in 26 bits (65535 s); the forced-end sum needs 27.
  localparam int unsigned MsW    = 26;
  localparam int unsigned TotW   = 27;

  // Reciprocal division by 1875 on a 27-bit dividend: q = (n * M) >> 38.
  // Dividing by 32 first and then by 1875 gives the quotient by 60000.
  localparam int unsigned ProdW  = 55;
  localparam int unsigned QuoLsb = 38;
  localparam int unsigned QuoW   = 17;
  localparam logic [27:0] RECIP_1875  = 28'd146601551;
  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [31:0] WET_GUARD_MS = 32'd1000;

  typedef enum logic [2:0] {
    REG_ALERT_ONE   = 3'd0,
    REG_ALERT_TWO   = 3'd1,
    REG_ALERT_THREE = 3'd2,
    REG_KILLER      = 3'd3,
    REG_KILLER_HOLD = 3'd4,
    REG_IDLE_CLEAR  = 3'd5,
    REG_FLOW_RATE   = 3'd6,
    REG_REMOTE_EN   = 3'd7
  } fdat_reg_t;

  localparam logic [2:0] LVL_NONE   = 3'd0;
  localparam logic [2:0] LVL_ONE    = 3'd1;
  localparam logic [2:0] LVL_TWO    = 3'd2;
  localparam logic [2:0] LVL_THREE  = 3'd3;
  localparam logic [2:0] LVL_KILLER = 3'd4;
  localparam logic [2:0] LVL_FORCE  = 3'd5;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_ON   = 2'd1;
  localparam logic [1:0] REQ_OFF  = 2'd2;

  // Configuration as the tick logic sees it, thresholds already in milliseconds.
  typedef struct packed {
    logic [MsW-1:0]  alert_one_ms;
    logic [MsW-1:0]  alert_two_ms;
    logic [MsW-1:0]  alert_three_ms;
    logic [MsW-1:0]  killer_ms;
    logic [TotW-1:0] force_ms;
    logic [MsW-1:0]  hold_ms;
    logic [MsW-1:0]  idle_ms;
    logic [15:0]     flow_rate;
    logic            remote_en;
  } fdat_cfg_t;

  // Per-word flags that travel alongside the volume computation.
  typedef struct packed {
    logic       started;
    logic       ended;
    logic [2:0] level;
    logic [1:0] req;
  } fdat_tick_t;

  // Load enables of the volume stages.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } fdat_adv_t;

  function automatic logic [TotW-1:0] sec_to_ms(input logic [16:0] secs);
    sec_to_ms = {10'd0, secs} * 27'd1000;
  endfunction

endpackage

`default_nettype wire

/* rtl/fdat_cfg.sv */
// Configuration register file of the flow duration alarm timer.
// Stores the thresholds pre-scaled to milliseconds; depends on fdat_pkg.
`default_nettype none

module fdat_cfg import fdat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output fdat_cfg_t   cfg
);

  fdat_cfg_t   cfg_r;
  logic [15:0] killer_s_r;
  logic [15:0] hold_s_r;
  logic        wr_en;

  assign cfg_ready = rst_n;
  assign wr_en     = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alert_one_ms   <= 26'd20000;
      cfg_r.alert_two_ms   <= 26'd40000;
      cfg_r.alert_three_ms <= 26'd60000;
      cfg_r.killer_ms      <= 26'd120000;
      cfg_r.force_ms       <= 27'd150000;
      cfg_r.hold_ms        <= 26'd30000;
      cfg_r.idle_ms        <= 26'd30000;
      cfg_r.flow_rate      <= 16'd100;
      cfg_r.remote_en      <= 1'b0;
      killer_s_r           <= 16'd120;
      hold_s_r             <= 16'd30;
    end else if (wr_en) begin
      case (fdat_reg_t'(cfg_index))
        REG_ALERT_ONE: begin
          cfg_r.alert_one_ms <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
        end
        REG_ALERT_TWO: begin
          cfg_r.alert_two_ms <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
        end
        REG_ALERT_THREE: begin
          cfg_r.alert_three_ms <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
        end
        REG_KILLER: begin
          killer_s_r      <= cfg_wdata;
          cfg_r.killer_ms <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
          cfg_r.force_ms  <= sec_to_ms({1'b0, cfg_wdata} + {1'b0, hold_s_r});
        end
        REG_KILLER_HOLD: begin
          hold_s_r       <= cfg_wdata;
          cfg_r.hold_ms  <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
          cfg_r.force_ms <= sec_to_ms({1'b0, killer_s_r} + {1'b0, cfg_wdata});
        end
        REG_IDLE_CLEAR: begin
          cfg_r.idle_ms <= MsW'(sec_to_ms({1'b0, cfg_wdata}));
        end
        REG_FLOW_RATE: begin
          cfg_r.flow_rate <= cfg_wdata;
        end
        REG_REMOTE_EN: begin
          cfg_r.remote_en <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/fdat_core.sv */
// Per-tick session, run and alarm state of the flow duration alarm timer.
// One word is evaluated per step; depends on fdat_pkg.
`default_nettype none

module fdat_core import fdat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [31:0] now_ms,
  input  logic        water_seen,
  input  logic        stop_button,
  input  fdat_cfg_t   cfg,
  output fdat_tick_t  tick_o,
  output logic [31:0] dur_o
);

  logic [31:0] session_start_r, session_start_nxt;
  logic [31:0] run_start_r,     run_start_nxt;
  logic [31:0] last_wet_r,      last_wet_nxt;
  logic        force_pend_r,    force_pend_nxt;
  logic [31:0] on_due_r,        on_due_nxt;
  logic        sw_off_r,        sw_off_nxt;
  fdat_tick_t  tick_r,          tick_nxt;
  logic [31:0] dur_r,           dur_nxt;

  logic [31:0] sess_age;
  logic [31:0] run_age;
  logic [31:0] dry_age;
  logic [31:0] due_at;

  assign sess_age = now_ms - session_start_r;
  assign run_age  = now_ms - run_start_r;
  assign dry_age  = now_ms - last_wet_r;
  assign due_at   = now_ms + {6'd0, cfg.hold_ms};

  always_comb begin
    session_start_nxt = session_start_r;
    run_start_nxt     = run_start_r;
    last_wet_nxt      = water_seen ? now_ms : last_wet_r;
    force_pend_nxt    = force_pend_r;
    on_due_nxt        = on_due_r;
    sw_off_nxt        = sw_off_r;
    tick_nxt          = '{started: 1'b0, ended: 1'b0, level: LVL_NONE, req: REQ_NONE};
    dur_nxt           = '0;

    // Button press or a pending forced end closes an open session.
    if (session_start_r != '0 && (stop_button || force_pend_r)) begin
      dur_nxt        = sess_age;
      tick_nxt.ended = 1'b1;
      if (cfg.remote_en && sw_off_nxt) begin
        sw_off_nxt   = 1'b0;
        tick_nxt.req = REQ_ON;
      end
      session_start_nxt = '0;
      run_start_nxt     = '0;
      force_pend_nxt    = 1'b0;
    end

    // A scheduled switch-on fires once its time has passed.
    if (on_due_r != '0 && now_ms > on_due_r) begin
      on_due_nxt = '0;
      if (cfg.remote_en && sw_off_nxt) begin
        sw_off_nxt   = 1'b0;
        tick_nxt.req = REQ_ON;
      end
    end

    if (session_start_nxt == '0 && water_seen) begin
      session_start_nxt = now_ms;
      tick_nxt.started  = (now_ms != '0);
      if (run_start_nxt == '0) begin
        run_start_nxt = now_ms;
      end
    end else if (session_start_nxt != '0) begin
      // Here the session was open before this word and was not closed above.
      if (!water_seen) begin
        dur_nxt           = sess_age;
        tick_nxt.ended    = 1'b1;
        session_start_nxt = '0;
      end else if (sess_age > WET_GUARD_MS) begin
        if (run_age >= {5'd0, cfg.force_ms}) begin
          force_pend_nxt = 1'b1;
          tick_nxt.level = LVL_FORCE;
        end else if (run_age >= {6'd0, cfg.killer_ms}) begin
          tick_nxt.level = LVL_KILLER;
          if (cfg.remote_en && !sw_off_nxt) begin
            sw_off_nxt   = 1'b1;
            tick_nxt.req = REQ_OFF;
          end
          on_due_nxt = due_at;
        end else if (run_age >= {6'd0, cfg.alert_three_ms}) begin
          tick_nxt.level = LVL_THREE;
        end else if (run_age >= {6'd0, cfg.alert_two_ms}) begin
          tick_nxt.level = LVL_TWO;
        end else if (run_age >= {6'd0, cfg.alert_one_ms}) begin
          tick_nxt.level = LVL_ONE;
        end
      end
    end

    // Only a dry word can clear the run, once the dry time exceeds the idle time.
    if (!water_seen && last_wet_r != '0 && run_start_nxt != '0 &&
        dry_age > {6'd0, cfg.idle_ms}) begin
      run_start_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_start_r <= '0;
      run_start_r     <= '0;
      last_wet_r      <= '0;
      force_pend_r    <= 1'b0;
      on_due_r        <= '0;
      sw_off_r        <= 1'b1;
    end else if (step) begin
      session_start_r <= session_start_nxt;
      run_start_r     <= run_start_nxt;
      last_wet_r      <= last_wet_nxt;
      force_pend_r    <= force_pend_nxt;
      on_due_r        <= on_due_nxt;
      sw_off_r        <= sw_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tick_r <= tick_nxt;
      dur_r  <= dur_nxt;
    end
  end

  assign tick_o = tick_r;
  assign dur_o  = dur_r;

endmodule

`default_nettype wire

/* rtl/fdat_vol.sv */
// Volume pipeline: gallons in hundredths = duration * flow / 60000, saturated.
// Splits the duration into whole minutes and a remainder; depends on fdat_pkg.
`default_nettype none

module fdat_vol import fdat_pkg::*; (
  input  logic        clk,
  input  fdat_adv_t   adv,
  input  logic [15:0] flow_rate,
  input  fdat_tick_t  tick_i,
  input  logic [31:0] dur_i,
  output fdat_tick_t  tick_o,
  output logic [31:0] dur_o,
  output logic [31:0] gal_o
);

  fdat_tick_t       tick2_r, tick3_r, tick4_r, tick5_r, tick6_r;
  logic [31:0]      dur2_r, dur3_r, dur4_r, dur5_r, dur6_r;
  logic [ProdW-1:0] prod2_r, prod5_r;
  logic [32:0]      qr3_r, qr4_r, qr5_r;
  logic [31:0]      qsub3_r;
  logic [31:0]      rr4_r;
  logic [31:0]      gal6_r;

  logic [QuoW-1:0]  quo3;
  logic [31:0]      rem_full;
  logic [15:0]      rem4;
  logic [QuoW-1:0]  quo6;
  logic [33:0]      sum6;

  assign quo3     = prod2_r[QuoLsb +: QuoW];
  assign rem_full = dur3_r - qsub3_r;
  assign rem4     = rem_full[15:0];
  assign quo6     = prod5_r[QuoLsb +: QuoW];
  assign sum6     = {1'b0, qr5_r} + 34'(quo6);

  always_ff @(posedge clk) begin
    // Whole minutes of the duration, by reciprocal multiply.
    if (adv.s2) begin
      tick2_r <= tick_i;
      dur2_r  <= dur_i;
      prod2_r <= ProdW'(dur_i[31:5]) * ProdW'(RECIP_1875);
    end
    if (adv.s3) begin
      tick3_r <= tick2_r;
      dur3_r  <= dur2_r;
      qr3_r   <= 33'(quo3) * 33'(flow_rate);
      qsub3_r <= 32'(quo3) * 32'(MS_PER_MIN);
    end
    // Remainder below one minute times the flow rate.
    if (adv.s4) begin
      tick4_r <= tick3_r;
      dur4_r  <= dur3_r;
      qr4_r   <= qr3_r;
      rr4_r   <= 32'(rem4) * 32'(flow_rate);
    end
    if (adv.s5) begin
      tick5_r <= tick4_r;
      dur5_r  <= dur4_r;
      qr5_r   <= qr4_r;
      prod5_r <= ProdW'(rr4_r[31:5]) * ProdW'(RECIP_1875);
    end
    if (adv.s6) begin
      tick6_r <= tick5_r;
      dur6_r  <= dur5_r;
      gal6_r  <= (sum6[33:32] != 2'd0) ? '1 : sum6[31:0];
    end
  end

  assign tick_o = tick6_r;
  assign dur_o  = dur6_r;
  assign gal_o  = gal6_r;

endmodule

`default_nettype wire

/* rtl/flow_duration_alarm_timer.sv */
// Flow duration alarm timer: sessions, alert levels and switch requests per tick word.
// Each accepted word passes the input register, the tick logic stage and the volume
// stages s2 to s6 that give gallons, and is then offered on out_*.
// Throughput: one word per cycle; stalls only back up through the seven-stage pipeline.
// Reset: synchronous active-low rst_n empties the pipeline, clears session state and loads
// the register defaults; the block accepts words on the first cycle after reset.
`default_nettype none

module flow_duration_alarm_timer import fdat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Tick words in.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_water_seen,
  input  logic        in_stop_button,
  // Result words out.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_session_started,
  output logic        out_session_ended,
  output logic [31:0] out_session_ms,
  output logic [31:0] out_gallons_centi,
  output logic [2:0]  out_alert_level,
  output logic [1:0]  out_switch_request,
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Stage 0 is the input register, stage 1 the tick logic output, stages 2 to 6 the
  // volume pipeline; stage 6 drives the output ports.
  localparam int unsigned NumStg = 7;

  logic [NumStg-1:0] vld_r, vld_nxt;
  logic [NumStg:0]   adv;

  logic [31:0] now0_r;
  logic        wet0_r;
  logic        btn0_r;

  fdat_cfg_t   cfg;
  fdat_tick_t  tick1;
  logic [31:0] dur1;
  fdat_tick_t  tick6;
  logic [31:0] dur6;
  logic [31:0] gal6;
  fdat_adv_t   vol_adv;
  logic        step;

  // A stage may load when it is empty or when its word moves on this cycle, so
  // bubbles close up and a waiting result does not block new words behind it.
  always_comb begin
    adv[NumStg] = !out_stall;
    for (int i = NumStg - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NumStg; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !rst_n || !adv[0];

  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      now0_r <= in_now_ms;
      wet0_r <= in_water_seen;
      btn0_r <= in_stop_button;
    end
  end

  // State advances exactly once per word, as the word leaves the input register.
  assign step = adv[1] && vld_r[0];

  assign vol_adv = '{s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};

  fdat_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fdat_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .now_ms      (now0_r),
    .water_seen  (wet0_r),
    .stop_button (btn0_r),
    .cfg         (cfg),
    .tick_o      (tick1),
    .dur_o       (dur1)
  );

  fdat_vol u_vol (
    .clk       (clk),
    .adv       (vol_adv),
    .flow_rate (cfg.flow_rate),
    .tick_i    (tick1),
    .dur_i     (dur1),
    .tick_o    (tick6),
    .dur_o     (dur6),
    .gal_o     (gal6)
  );

  assign out_valid           = vld_r[NumStg-1];
  assign out_session_started = tick6.started;
  assign out_session_ended   = tick6.ended;
  assign out_session_ms      = dur6;
  assign out_gallons_centi   = gal6;
  assign out_alert_level     = tick6.level;
  assign out_switch_request  = tick6.req;

  // A word that closes no session carries zero duration and zero volume.
  a_no_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_session_ended |-> out_session_ms == '0 && out_gallons_centi == '0)
    else $error("duration or volume reported without a session end");

  // Levels are only evaluated on an open, wet session, which cannot also close.
  a_level_no_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alert_level != LVL_NONE |-> !out_session_ended)
    else $error("alert level reported on a closing word");

  // An off request only comes from the killer level.
  a_off_killer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request == REQ_OFF |-> out_alert_level == LVL_KILLER)
    else $error("off request without killer level");

  // The input side is held off only while the input register is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> vld_r[0])
    else $error("input stalled with an empty input register");

endmodule

`default_nettype wire

/* test/flow_timer_checker.sv */
`timescale 1ns / 100ps
// Result checker for the flow duration alarm timer: predicts one result word per tick word.
// Watches the tick, result and register write channels of the block; uses fdat_pkg codes.
module flow_timer_checker import fdat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_now_ms,
  input  logic        in_water_seen,
  input  logic        in_stop_button,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_session_started,
  input  logic        out_session_ended,
  input  logic [31:0] out_session_ms,
  input  logic [31:0] out_gallons_centi,
  input  logic [2:0]  out_alert_level,
  input  logic [1:0]  out_switch_request,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output logic [5:0]  levels_seen,
  output logic [2:0]  requests_seen
);

  localparam logic [31:0] MsPerSec = 32'd1000;

  typedef struct packed {
    logic        started;
    logic        ended;
    logic [31:0] dur_ms;
    logic [31:0] gallons;
    logic [2:0]  level;
    logic [1:0]  req;
  } flow_word_t;

  // Register copies.
  logic [15:0] alert1_s, alert2_s, alert3_s, killer_s, hold_s, idle_s, flow_rate;
  logic        remote_en;

  // Session state; a zero timestamp means "none".
  logic [31:0] session_t0, run_t0, last_wet_ms, on_due_ms;
  logic        force_end, switch_off;

  flow_word_t expected_words[$];

  function automatic logic [31:0] centi_gallons(input logic [31:0] ms);
    logic [63:0] v;
    v = ({32'd0, ms} * {48'd0, flow_rate}) / 64'd60000;
    return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // A request only takes effect when enabled and when it changes the switch.
  function automatic logic [1:0] switch_request_apply(input logic [1:0] want,
                                                      input logic [1:0] req);
    if (remote_en && want == REQ_ON && switch_off) begin
      switch_off = 1'b0;
      return REQ_ON;
    end
    if (remote_en && want == REQ_OFF && !switch_off) begin
      switch_off = 1'b1;
      return REQ_OFF;
    end
    return req;
  endfunction

  function automatic flow_word_t predict_tick(input logic [31:0] now, input logic wet,
                                              input logic button);
    flow_word_t w;
    logic [31:0] secs;
    w = '0;
    if (session_t0 != 0 && (button || force_end)) begin
      w.dur_ms  = now - session_t0;
      w.gallons = centi_gallons(w.dur_ms);
      w.ended   = 1'b1;
      w.req     = switch_request_apply(REQ_ON, w.req);
      session_t0 = '0;
      run_t0     = '0;
      force_end  = 1'b0;
    end
    if (on_due_ms != 0 && now > on_due_ms) begin
      on_due_ms = '0;
      w.req = switch_request_apply(REQ_ON, w.req);
    end
    if (wet) last_wet_ms = now;
    if (session_t0 == 0 && wet) begin
      session_t0 = now;
      w.started  = (now != 0);
      if (run_t0 == 0) run_t0 = now;
    end else if (session_t0 != 0) begin
      if (!wet) begin
        w.dur_ms  = now - session_t0;
        w.gallons = centi_gallons(w.dur_ms);
        w.ended   = 1'b1;
        session_t0 = '0;
      end else if (now - session_t0 > MsPerSec) begin
        // Levels are tested from the top down, so unordered thresholds resolve high.
        secs = (now - run_t0) / MsPerSec;
        if (secs >= 32'(killer_s) + 32'(hold_s)) begin
          force_end = 1'b1;
          w.level = LVL_FORCE;
        end else if (secs >= 32'(killer_s)) begin
          w.level   = LVL_KILLER;
          w.req     = switch_request_apply(REQ_OFF, w.req);
          on_due_ms = now + 32'(hold_s) * MsPerSec;
        end else if (secs >= 32'(alert3_s)) begin
          w.level = LVL_THREE;
        end else if (secs >= 32'(alert2_s)) begin
          w.level = LVL_TWO;
        end else if (secs >= 32'(alert1_s)) begin
          w.level = LVL_ONE;
        end
      end
    end
    if (last_wet_ms != 0 && run_t0 != 0 && (now - last_wet_ms) > 32'(idle_s) * MsPerSec)
      run_t0 = '0;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    flow_word_t w;
    if (!rst_n) begin
      alert1_s    = 16'd20;
      alert2_s    = 16'd40;
      alert3_s    = 16'd60;
      killer_s    = 16'd120;
      hold_s      = 16'd30;
      idle_s      = 16'd30;
      flow_rate   = 16'd100;
      remote_en   = 1'b0;
      session_t0  = '0;
      run_t0      = '0;
      last_wet_ms = '0;
      on_due_ms   = '0;
      force_end   = 1'b0;
      switch_off  = 1'b1;
      expected_words.delete();
      levels_seen   = '0;
      requests_seen = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ALERT_ONE:   alert1_s  = cfg_wdata;
          REG_ALERT_TWO:   alert2_s  = cfg_wdata;
          REG_ALERT_THREE: alert3_s  = cfg_wdata;
          REG_KILLER:      killer_s  = cfg_wdata;
          REG_KILLER_HOLD: hold_s    = cfg_wdata;
          REG_IDLE_CLEAR:  idle_s    = cfg_wdata;
          REG_FLOW_RATE:   flow_rate = cfg_wdata;
          REG_REMOTE_EN:   remote_en = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        w = predict_tick(in_now_ms, in_water_seen, in_stop_button);
        levels_seen[w.level] = 1'b1;
        requests_seen[w.req] = 1'b1;
        expected_words.push_back(w);
      end
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("result word arrived with no tick word waiting for it");
          fail_count++;
        end else begin
          w = expected_words.pop_front();
          check_field("session_started", 32'(w.started), 32'(out_session_started));
          check_field("session_ended", 32'(w.ended), 32'(out_session_ended));
          check_field("session_ms", w.dur_ms, out_session_ms);
          check_field("gallons_centi", w.gallons, out_gallons_centi);
          check_field("alert_level", 32'(w.level), 32'(out_alert_level));
          check_field("switch_request", 32'(w.req), 32'(out_switch_request));
          words_checked++;
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

/* test/tb_flow_duration_alarm_timer.sv */
`timescale 1ns / 100ps
// Testbench top for flow_duration_alarm_timer: drives tick words and register writes.
// Depends on fdat_pkg, the block itself and flow_timer_checker, which does all checking.
module tb_flow_duration_alarm_timer import fdat_pkg::*;;

  // Generous bound: every tick waiting out the longest sender gap, receiver stall and the
  // pipeline in series would still finish well inside this.
  localparam int CycleLimit = 650_000;
  localparam int TicksPerPhase = 175;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_stall, in_water_seen, in_stop_button;
  logic [31:0] in_now_ms;
  logic        out_valid, out_stall, out_session_started, out_session_ended;
  logic [31:0] out_session_ms, out_gallons_centi;
  logic [2:0]  out_alert_level;
  logic [1:0]  out_switch_request;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;

  int          fail_count, pending, words_checked;
  logic [5:0]  levels_seen;
  logic [2:0]  requests_seen;

  // Stimulus bookkeeping. The sender and receiver each toggle a burst mode now and then,
  // in which they never idle, so back-to-back stretches are mixed with ragged ones.
  int          ticks_sent = 0;
  int          settings_count = 0;
  int          cycle_count = 0;
  logic        feed_burst = 1'b0;
  logic        drain_burst = 1'b0;
  logic [31:0] flow_clock_ms = 32'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  flow_duration_alarm_timer u_dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_now_ms, .in_water_seen, .in_stop_button,
    .out_valid, .out_stall, .out_session_started, .out_session_ended,
    .out_session_ms, .out_gallons_centi, .out_alert_level, .out_switch_request,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  flow_timer_checker u_checker (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_now_ms, .in_water_seen, .in_stop_button,
    .out_valid, .out_stall, .out_session_started, .out_session_ended,
    .out_session_ms, .out_gallons_centi, .out_alert_level, .out_switch_request,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata,
    .fail_count, .pending, .words_checked, .levels_seen, .requests_seen
  );

  // All tasks below start and end just after a falling edge, so every input change
  // lands on a falling edge and the block samples it half a period later.

  // Offers one tick word after a random gap and holds it until the block takes it.
  task automatic send_tick(input logic [31:0] now, input logic wet, input logic button);
    int gap;
    gap = feed_burst ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_now_ms      = now;
    in_water_seen  = wet;
    in_stop_button = button;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    ticks_sent++;
    if ($urandom_range(0, 39) == 0) feed_burst = !feed_burst;
  endtask

  // Stops sending and waits until the checker holds no outstanding expectation. Since
  // every tick word yields exactly one result word, the block is idle after that.
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Drives one register write and waits for the handshake. The caller lowers cfg_valid
  // once its last write is done, so valid never dips between back-to-back writes.
  task automatic write_reg(input fdat_reg_t idx, input logic [15:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes the whole register set while the block is idle.
  task automatic program_settings(input logic [15:0] a1, input logic [15:0] a2,
                                  input logic [15:0] a3, input logic [15:0] killer,
                                  input logic [15:0] hold, input logic [15:0] idle,
                                  input logic [15:0] rate, input logic remote);
    wait_drained();
    write_reg(REG_ALERT_ONE, a1);
    write_reg(REG_ALERT_TWO, a2);
    write_reg(REG_ALERT_THREE, a3);
    write_reg(REG_KILLER, killer);
    write_reg(REG_KILLER_HOLD, hold);
    write_reg(REG_IDLE_CLEAR, idle);
    write_reg(REG_FLOW_RATE, rate);
    write_reg(REG_REMOTE_EN, {15'd0, remote});
    cfg_valid = 1'b0;
    settings_count++;
  endtask

  // One water session as a sensor would report it: a dry stretch, a run of wet ticks with
  // rising timestamps, then usually a dry tick that closes it. Mixed in are fully random
  // words, stray button presses, jumps to just below the timestamp wrap and to zero, and
  // now and then a session left open so it merges into the next one.
  task automatic flow_session();
    int r, wet_ticks;
    logic [31:0] step;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      flow_clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 30000));
    end else if (r < 5) begin
      flow_clock_ms = 32'd0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) flow_clock_ms += $urandom_range(0, 8000);
      else if (r < 95) flow_clock_ms += $urandom_range(8000, 40000);
      else flow_clock_ms += $urandom_range(40000, 100_000_000);
    end
    if ($urandom_range(0, 3) == 0)
      send_tick(flow_clock_ms, 1'b0, $urandom_range(0, 9) == 0);
    wet_ticks = $urandom_range(1, 40);
    for (int i = 0; i < wet_ticks; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_tick($urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        // Mostly sensor-like spacing; large steps let the highest thresholds be reached.
        if (r < 13) step = $urandom_range(0, 1000);
        else if (r < 93) step = $urandom_range(300, 2500);
        else if (r < 98) step = $urandom_range(2500, 20000);
        else step = $urandom_range(1_000_000, 80_000_000);
        flow_clock_ms += step;
        send_tick(flow_clock_ms, 1'b1, r >= 96);
      end
    end
    r = $urandom_range(0, 99);
    flow_clock_ms += $urandom_range(0, 3000);
    if (r < 80) send_tick(flow_clock_ms, 1'b0, $urandom_range(0, 7) == 0);
    else if (r < 90) send_tick(flow_clock_ms, 1'b1, 1'b1);
  endtask

  // Receiver: before each result word it stalls for a random number of cycles, then
  // takes the word as soon as one is offered.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = drain_burst ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) drain_burst = !drain_burst;
    end
  end

  // Watchdog: a hung handshake or a lost result word ends the run here.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk) cycle_count++;
    $display("flow_duration_alarm_timer test failed");
    $finish;
  end

  initial begin
    logic [15:0] a1, a2, a3, killer, hold, idle, rate;
    logic        remote;
    int          phase_goal;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_now_ms      = '0;
    in_water_seen  = 1'b0;
    in_stop_button = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_ALERT_ONE;
    cfg_wdata      = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. Short thresholds (2, 4, 6, 8 s, hold 3 s, idle 5 s), full flow rate
    // and switching enabled, so a handful of ticks walks through every level.
    program_settings(16'd2, 16'd4, 16'd6, 16'd8, 16'd3, 16'd5, 16'hFFFF, 1'b1);
    send_tick(32'd0, 1'b1, 1'b0);            // a session opened at time zero does not count
    send_tick(32'd1000, 1'b1, 1'b0);         // real start, run start set
    send_tick(32'd2000, 1'b1, 1'b0);         // exactly 1000 ms open: no level yet
    send_tick(32'd3001, 1'b1, 1'b0);         // level one
    send_tick(32'd5000, 1'b1, 1'b0);         // level two
    send_tick(32'd7000, 1'b1, 1'b0);         // level three
    send_tick(32'd9000, 1'b1, 1'b0);         // killer while the switch is already off
    send_tick(32'd10000, 1'b1, 1'b0);        // killer again, on request rescheduled
    send_tick(32'd12000, 1'b1, 1'b0);        // forced end now pending
    send_tick(32'd12500, 1'b1, 1'b0);        // forced close with on request, reopens
    send_tick(32'd13500, 1'b1, 1'b0);        // due on request while already on
    send_tick(32'd22000, 1'b1, 1'b0);        // killer with a real off request
    send_tick(32'd25001, 1'b0, 1'b0);        // due on request fires, dry close
    send_tick(32'd31000, 1'b0, 1'b0);        // dry long enough to clear the run start
    send_tick(32'd32000, 1'b1, 1'b1);        // button with no session open
    send_tick(32'd33000, 1'b1, 1'b1);        // button closes and reopens in one tick
    send_tick(32'hFFFF_C000, 1'b0, 1'b0);    // dry close of a very long session
    send_tick(32'hFFFF_D000, 1'b1, 1'b0);    // start just below the wrap
    send_tick(32'hFFFF_F448, 1'b1, 1'b0);    // killer whose on time wraps to zero
    send_tick(32'hFFFF_FFFF, 1'b1, 1'b0);    // largest timestamp, forced end pending
    send_tick(32'h0000_0010, 1'b1, 1'b0);    // forced close across the wrap, reopens
    send_tick(32'hF000_0000, 1'b0, 1'b0);    // huge duration: gallons saturate
    send_tick(32'd0, 1'b1, 1'b0);            // wet at time zero again
    send_tick(32'd0, 1'b1, 1'b1);            // same timestamp, button, still no session
    send_tick(32'd100, 1'b0, 1'b1);          // dry with button and nothing open

    // Random part: eight register settings, each followed by a batch of sessions.
    for (int phase = 0; phase < 8; phase++) begin
      a1 = 16'($urandom_range(0, 6));
      a2 = a1 + 16'($urandom_range(0, 6));
      a3 = a2 + 16'($urandom_range(0, 6));
      killer = a3 + 16'($urandom_range(0, 8));
      hold = 16'($urandom_range(0, 6));
      idle = 16'($urandom_range(1, 12));
      rate = 16'($urandom);
      remote = 1'b1;
      case (phase)
        0: begin
          // Power-on values with switching enabled.
          a1 = 16'd20; a2 = 16'd40; a3 = 16'd60; killer = 16'd120;
          hold = 16'd30; idle = 16'd30; rate = 16'd100;
        end
        2: begin
          a1 = '0; a2 = '0; a3 = '0; killer = '0; hold = '0; idle = '0; rate = '0;
        end
        3: begin
          a1 = '1; a2 = '1; a3 = '1; killer = '1; hold = '1; idle = '1; rate = '1;
        end
        4: begin
          // Thresholds in no particular order.
          a1 = 16'($urandom_range(0, 20)); a2 = 16'($urandom_range(0, 20));
          a3 = 16'($urandom_range(0, 20)); killer = 16'($urandom_range(0, 20));
          remote = 1'($urandom_range(0, 1));
        end
        5: remote = 1'b0;
        6: begin
          hold = '0; rate = '0;
        end
        default: ;
      endcase
      program_settings(a1, a2, a3, killer, hold, idle, rate, remote);
      phase_goal = ticks_sent + TicksPerPhase;
      while (ticks_sent < phase_goal) begin
        flow_session();
        // Occasionally hold the sender off until every result is back.
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Sent %0d tick words under %0d register settings; %0d result words compared.",
             ticks_sent, settings_count, words_checked);
    $display("Alert levels reached (bit per level 5..0): %b; switch requests (off, on, none): %b",
             levels_seen, requests_seen);
    if (fail_count == 0) begin
      $display("flow_duration_alarm_timer test passed");
    end else begin
      $display("flow_duration_alarm_timer test failed");
    end
    $finish;
  end

endmodule
